FILE: rtl/core/multilevel_priority_ready_queue_assert.svh
// assertion macros for the ready queue top level
// no dependencies
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
// implication checked every clock while out of reset
`define MPRQ_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication checked every clock while out of reset
`define MPRQ_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/mprq_pkg.sv
// types and codes shared by the ready queue controller and datapath
// no dependencies
package mprq_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_CHANGE = 3'd2,
    REQ_POP    = 3'd3,
    REQ_QUERY  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_QUEUED     = 2'd2,
    ST_NOT_QUEUED = 2'd3
  } status_e;

  // controller commands to the datapath
  typedef struct packed {
    logic latch;    // capture request
    logic rd_thr;   // read links and level of the working thread
    logic unlink;   // write unlink updates
    logic rd_lvl;   // read tail of the target level
    logic link;     // write link updates
    logic pick_top; // select popped thread as working thread
    logic finish;   // register result
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic thr_ok;
    logic thr_queued;
    logic any_level;
  } dp_sts_t;

endpackage

FILE: rtl/core/mprq_ctrl.sv
// sequencer for the ready queue: walks unlink and link steps of one request
// depends on mprq_pkg
module mprq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2:0]          req_type_i,
  input  mprq_pkg::dp_sts_t   sts_i,
  output mprq_pkg::dp_cmd_t   cmd_o,
  output logic                busy_o,
  output logic                pop_o,
  output logic [1:0]          status_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_RDTHR  = 7'b0000100,
    S_UNLINK = 7'b0001000,
    S_RDLVL  = 7'b0010000,
    S_LINK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] req_q;
  logic [1:0] status_q, status_d;
  logic lnk_q, lnk_d, pop_q, pop_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    lnk_d = lnk_q;
    pop_d = pop_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_d = mprq_pkg::ST_OK;
        lnk_d = 1'b0;
        pop_d = 1'b0;
        state_d = S_DONE;
        case (req_q)
          mprq_pkg::REQ_INSERT: begin
            if (!sts_i.thr_ok) status_d = mprq_pkg::ST_NOT_QUEUED;
            else if (sts_i.thr_queued) status_d = mprq_pkg::ST_QUEUED;
            else begin
              lnk_d = 1'b1;
              state_d = S_RDLVL;
            end
          end
          mprq_pkg::REQ_REMOVE, mprq_pkg::REQ_CHANGE: begin
            if (!sts_i.thr_ok || !sts_i.thr_queued) status_d = mprq_pkg::ST_NOT_QUEUED;
            else begin
              lnk_d = (req_q == mprq_pkg::REQ_CHANGE);
              state_d = S_RDTHR;
            end
          end
          mprq_pkg::REQ_POP: begin
            if (!sts_i.any_level) status_d = mprq_pkg::ST_POP_EMPTY;
            else begin
              cmd_o.pick_top = 1'b1;
              pop_d = 1'b1;
              state_d = S_RDTHR;
            end
          end
          default: ;
        endcase
      end
      S_RDTHR: begin
        cmd_o.rd_thr = 1'b1;
        state_d = S_UNLINK;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = lnk_q ? S_RDLVL : S_DONE;
      end
      S_RDLVL: begin
        cmd_o.rd_lvl = 1'b1;
        state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= mprq_pkg::ST_OK;
      lnk_q <= 1'b0;
      pop_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      lnk_q <= lnk_d;
      pop_q <= pop_d;
    end
  end

  // request type capture
  always_ff @(posedge clk_i) begin
    if (cmd_o.latch) req_q <= req_type_i;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign pop_o    = pop_q;
  assign status_o = status_q;

endmodule

FILE: rtl/core/mprq_dp.sv
// ready queue datapath: link memories, level bitmap, counters, result registers
// depends on mprq_pkg
module mprq_dp #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mprq_pkg::dp_cmd_t cmd_i,
  input  logic [5:0]        thread_id_i,
  input  logic [5:0]        priority_req_i,
  input  logic              pop_i,
  input  logic [1:0]        status_i,
  output mprq_pkg::dp_sts_t sts_o,
  output logic              done_o,
  output logic              popped_valid_o,
  output logic [5:0]        popped_thread_o,
  output logic              any_ready_o,
  output logic [5:0]        top_priority_o,
  output logic [6:0]        ready_count_o,
  output logic [1:0]        status_o
);

  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LKW = TW + 1;
  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam logic [LKW-1:0] NO_LINK = LKW'(NUM_THREADS);

  // memories
  logic [LKW-1:0] next_mem [NUM_THREADS];
  logic [LKW-1:0] prev_mem [NUM_THREADS];
  logic [LW-1:0]  lvl_mem  [NUM_THREADS];
  logic [TW-1:0]  head_mem [NUM_LEVELS];
  logic [TW-1:0]  tail_mem [NUM_LEVELS];

  logic [NUM_LEVELS-1:0]  nonempty_q;
  logic [NUM_THREADS-1:0] queued_q;
  logic [CW-1:0]          total_q;

  logic [TW-1:0]  thr_q;
  logic [LW-1:0]  pri_q;
  logic           thr_ok_q;
  logic [LKW-1:0] prv_q, nxt_q;
  logic [LW-1:0]  olv_q;
  logic [TW-1:0]  otail_q;
  logic [TW-1:0]  head_rd_q;

  // highest non-empty level search
  logic [LW-1:0] top_lv;
  logic          any_lv;
  always_comb begin
    top_lv = '0;
    any_lv = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty_q[i]) begin
        top_lv = LW'(i);
        any_lv = 1'b1;
      end
    end
  end

  // saturated level of the request
  logic [LW-1:0] pri_sat;
  always_comb begin
    if (32'(priority_req_i) >= NUM_LEVELS) pri_sat = LW'(NUM_LEVELS - 1);
    else pri_sat = LW'(priority_req_i);
  end

  assign sts_o.thr_ok     = thr_ok_q;
  assign sts_o.thr_queued = queued_q[thr_q];
  assign sts_o.any_level  = any_lv;

  // head read of the top level, registered memory read
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[top_lv];
  end

  // request capture and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      thr_q    <= TW'(thread_id_i);
      thr_ok_q <= (32'(thread_id_i) < NUM_THREADS);
      pri_q    <= pri_sat;
    end
    if (cmd_i.pick_top) thr_q <= head_rd_q;
    if (cmd_i.rd_thr) begin
      prv_q <= prev_mem[thr_q];
      nxt_q <= next_mem[thr_q];
      olv_q <= lvl_mem[thr_q];
    end
    if (cmd_i.rd_lvl) otail_q <= tail_mem[pri_q];
  end

  // memory writes, one step each of unlink and link
  always_ff @(posedge clk_i) begin
    if (cmd_i.unlink) begin
      if (prv_q != NO_LINK) next_mem[prv_q[TW-1:0]] <= nxt_q;
      else head_mem[olv_q] <= nxt_q[TW-1:0];
      if (nxt_q != NO_LINK) prev_mem[nxt_q[TW-1:0]] <= prv_q;
      else tail_mem[olv_q] <= prv_q[TW-1:0];
    end
    if (cmd_i.link) begin
      lvl_mem[thr_q]  <= pri_q;
      next_mem[thr_q] <= NO_LINK;
      if (nonempty_q[pri_q]) begin
        next_mem[otail_q] <= LKW'(thr_q);
        prev_mem[thr_q]   <= LKW'(otail_q);
      end else begin
        prev_mem[thr_q]  <= NO_LINK;
        head_mem[pri_q]  <= thr_q;
      end
      tail_mem[pri_q] <= thr_q;
    end
  end

  // level bitmap, queued flags and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      queued_q   <= '0;
      total_q    <= '0;
      done_o     <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.unlink) begin
        if (prv_q == NO_LINK && nxt_q == NO_LINK) nonempty_q[olv_q] <= 1'b0;
        queued_q[thr_q] <= 1'b0;
        total_q <= total_q - 1'b1;
      end
      if (cmd_i.link) begin
        nonempty_q[pri_q] <= 1'b1;
        queued_q[thr_q] <= 1'b1;
        total_q <= total_q + 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      popped_valid_o  <= pop_i;
      popped_thread_o <= pop_i ? 6'(thr_q) : 6'd0;
      any_ready_o     <= (total_q != '0);
      top_priority_o  <= 6'(top_lv);
      ready_count_o   <= 7'(total_q);
      status_o        <= status_i;
    end
  end

endmodule

FILE: rtl/core/multilevel_priority_ready_queue.sv
// Ready queue of thread identifiers, one FIFO per priority level.
// Command channel: a request (req_type_i, thread_id_i, priority_req_i) is
// taken at a rising edge with start high and busy low.
// Result channel: exactly one result per request, shown for one cycle with
// done_o high; the receiver cannot stall, so it must take it then.
// After acceptance the sequencer decides the request: rejected requests,
// queries and pop on empty then go straight to the result, insert reads the
// tail of the target level and links, remove and pop read the thread and
// unlink it, and change of priority does both. A new request can be taken
// in the cycle done_o is high. Each thread unlink needs one read and one
// write step of the link memories, each link one more read and write.
// busy stays high until done_o, so one request is in work at a time.
// Reset (rst_ni low) empties every level; link memories are not cleared
// and their contents are only used for queued threads or non-empty levels.
// Depends on mprq_pkg, mprq_ctrl, mprq_dp and the assertion macro header.
`include "multilevel_priority_ready_queue_assert.svh"
module multilevel_priority_ready_queue #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type_i,
  input  logic [5:0] thread_id_i,
  input  logic [5:0] priority_req_i,
  output logic       done_o,
  output logic       popped_valid_o,
  output logic [5:0] popped_thread_o,
  output logic       any_ready_o,
  output logic [5:0] top_priority_o,
  output logic [6:0] ready_count_o,
  output logic [1:0] status_o
);

  mprq_pkg::dp_cmd_t cmd;
  mprq_pkg::dp_sts_t sts;
  logic pop;
  logic [1:0] st;

  mprq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i, .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .pop_o(pop), .status_o(st)
  );

  mprq_dp #(.NUM_LEVELS(NUM_LEVELS), .NUM_THREADS(NUM_THREADS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .thread_id_i, .priority_req_i, .pop_i(pop),
    .status_i(st), .sts_o(sts), .done_o, .popped_valid_o, .popped_thread_o,
    .any_ready_o, .top_priority_o, .ready_count_o, .status_o
  );

  // a result only ends a busy period
  `MPRQ_ASSERT_NXT(a_done_after_busy, clk_i, rst_ni, cmd.finish, done_o && !busy)
  // a popped thread always comes with ok status
  `MPRQ_ASSERT_IMP(a_pop_ok, clk_i, rst_ni, done_o && popped_valid_o,
    status_o == mprq_pkg::ST_OK)
  // count and ready flag agree
  `MPRQ_ASSERT_IMP(a_ready_cnt, clk_i, rst_ni, done_o,
    any_ready_o == (ready_count_o != 7'd0))

endmodule

FILE: test/multilevel_priority_ready_queue_tb.sv
// self-checking testbench for the multilevel priority ready queue
// depends on mprq_pkg and the multilevel_priority_ready_queue top level
module multilevel_priority_ready_queue_tb;

  localparam int NTHR = 64;
  localparam int NUM_RANDOM = 600;
  localparam int CALM_TAIL = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0] req;
    logic [5:0] tid;
    logic [5:0] pri;
    bit         drain;
  } request_t;

  typedef struct {
    logic       pv;
    logic [5:0] pt;
    logic       ar;
    logic [5:0] tp;
    logic [6:0] rc;
    logic [1:0] st;
  } summary_t;

  logic       clk_i, rst_ni, start, busy, done_o;
  logic [2:0] req_type_i;
  logic [5:0] thread_id_i, priority_req_i;
  logic       popped_valid_o, any_ready_o;
  logic [5:0] popped_thread_o, top_priority_o;
  logic [6:0] ready_count_o;
  logic [1:0] status_o;

  multilevel_priority_ready_queue uut (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i, .thread_id_i, .priority_req_i,
    .done_o, .popped_valid_o, .popped_thread_o, .any_ready_o,
    .top_priority_o, .ready_count_o, .status_o
  );

  request_t pending_reqs[$];
  summary_t expected_summaries[$];
  int mismatches = 0;
  int cycles = 0;
  int gap = 0;
  int generated = 0;
  bit calm = 0;
  bit took = 0;

  // shadow copy of the ready queue
  bit [63:0] lvl_busy_q;
  bit [63:0] thr_queued_q;
  int head_q[64], tail_q[64], next_q[NTHR], prev_q[NTHR], thr_lvl_q[NTHR];
  int total_q;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function void shadow_link(int t, int lv);
    thr_lvl_q[t] = lv;
    next_q[t] = NTHR;
    if (lvl_busy_q[lv]) begin
      next_q[tail_q[lv]] = t;
      prev_q[t] = tail_q[lv];
    end else begin
      prev_q[t] = NTHR;
      head_q[lv] = t;
      lvl_busy_q[lv] = 1;
    end
    tail_q[lv] = t;
    thr_queued_q[t] = 1;
    total_q++;
  endfunction

  function void shadow_unlink(int t);
    int lv, p, n;
    lv = thr_lvl_q[t];
    p = prev_q[t];
    n = next_q[t];
    if (p < NTHR) next_q[p] = n;
    else head_q[lv] = n;
    if (n < NTHR) prev_q[n] = p;
    else tail_q[lv] = p;
    if (p >= NTHR && n >= NTHR) lvl_busy_q[lv] = 0;
    thr_queued_q[t] = 0;
    total_q--;
  endfunction

  function int highest_level();
    for (int i = 63; i >= 0; i--) if (lvl_busy_q[i]) return i;
    return -1;
  endfunction

  // apply one transaction to the shadow queue and return its summary
  function summary_t apply_request(request_t r);
    summary_t s;
    int t, top;
    s = '{pv: 0, pt: 0, ar: 0, tp: 0, rc: 0, st: mprq_pkg::ST_OK};
    t = r.tid;
    case (r.req)
      mprq_pkg::REQ_INSERT: begin
        if (thr_queued_q[t]) s.st = mprq_pkg::ST_QUEUED;
        else shadow_link(t, r.pri);
      end
      mprq_pkg::REQ_REMOVE: begin
        if (!thr_queued_q[t]) s.st = mprq_pkg::ST_NOT_QUEUED;
        else shadow_unlink(t);
      end
      mprq_pkg::REQ_CHANGE: begin
        if (!thr_queued_q[t]) s.st = mprq_pkg::ST_NOT_QUEUED;
        else begin
          shadow_unlink(t);
          shadow_link(t, r.pri);
        end
      end
      mprq_pkg::REQ_POP: begin
        top = highest_level();
        if (top < 0) s.st = mprq_pkg::ST_POP_EMPTY;
        else begin
          s.pv = 1;
          s.pt = 6'(head_q[top]);
          shadow_unlink(head_q[top]);
        end
      end
      default: ;
    endcase
    top = highest_level();
    s.tp = (top < 0) ? 6'd0 : top[5:0];
    s.ar = (total_q != 0);
    s.rc = total_q[6:0];
    return s;
  endfunction

  function int any_queued_thread();
    int k;
    k = $urandom_range(0, NTHR - 1);
    for (int i = 0; i < NTHR; i++)
      if (thr_queued_q[(k + i) % NTHR]) return (k + i) % NTHR;
    return k;
  endfunction

  // random transaction biased by phase: fill-heavy or drain-heavy
  function request_t random_request(bit filling);
    request_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.tid = 6'($urandom_range(0, NTHR - 1));
    r.pri = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
                                        : 6'($urandom_range(0, 63));
    r.drain = 0;
    if (roll < (filling ? 55 : 20)) r.req = mprq_pkg::REQ_INSERT;
    else if (roll < (filling ? 65 : 40)) r.req = mprq_pkg::REQ_REMOVE;
    else if (roll < (filling ? 78 : 55)) r.req = mprq_pkg::REQ_CHANGE;
    else if (roll < 92) r.req = mprq_pkg::REQ_POP;
    else if (roll < 96) r.req = mprq_pkg::REQ_QUERY;
    else r.req = 3'($urandom_range(5, 7));
    if ((r.req == mprq_pkg::REQ_REMOVE || r.req == mprq_pkg::REQ_CHANGE) &&
        $urandom_range(0, 3) != 0)
      r.tid = 6'(any_queued_thread());
    return r;
  endfunction

  function void push_req(logic [2:0] q, logic [5:0] t, logic [5:0] p);
    pending_reqs.push_back('{req: q, tid: t, pri: p, drain: 0});
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 0;
    end else if (!(start && !took)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain && expected_summaries.size() > 0)) begin
        request_t r;
        r = pending_reqs.pop_front();
        req_type_i <= r.req;
        thread_id_i <= r.tid;
        priority_req_i <= r.pri;
        start <= 1;
        if (!calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 12);
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: check results and predict accepted transactions on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      took <= start && !busy;
      if (done_o) begin
        if (expected_summaries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          summary_t e;
          e = expected_summaries.pop_front();
          if (popped_valid_o !== e.pv || popped_thread_o !== e.pt ||
              any_ready_o !== e.ar || top_priority_o !== e.tp ||
              ready_count_o !== e.rc || status_o !== e.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pv=%0d pt=%0d ar=%0d tp=%0d rc=%0d st=%0d, %s",
                       e.pv, e.pt, e.ar, e.tp, e.rc, e.st,
                       $sformatf("got pv=%0d pt=%0d ar=%0d tp=%0d rc=%0d st=%0d",
                                 popped_valid_o, popped_thread_o, any_ready_o,
                                 top_priority_o, ready_count_o, status_o));
          end
        end
      end
      if (start && !busy)
        expected_summaries.push_back(apply_request('{req: req_type_i, tid: thread_id_i,
                                                     pri: priority_req_i, drain: 0}));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit filling;
    rst_ni = 0;
    start = 0;
    req_type_i = mprq_pkg::REQ_QUERY;
    thread_id_i = 0;
    priority_req_i = 0;
    lvl_busy_q = 0;
    thr_queued_q = 0;
    total_q = 0;
    // directed: empty queue, extremes, duplicates, same-level moves, odd codes
    push_req(mprq_pkg::REQ_QUERY, 0, 0);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    push_req(mprq_pkg::REQ_REMOVE, 0, 0);
    push_req(mprq_pkg::REQ_CHANGE, 63, 63);
    push_req(mprq_pkg::REQ_INSERT, 0, 0);
    push_req(mprq_pkg::REQ_INSERT, 63, 63);
    push_req(mprq_pkg::REQ_INSERT, 0, 5);
    push_req(mprq_pkg::REQ_INSERT, 5, 63);
    push_req(mprq_pkg::REQ_INSERT, 42, 63);
    push_req(mprq_pkg::REQ_CHANGE, 63, 63);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    push_req(mprq_pkg::REQ_CHANGE, 42, 0);
    push_req(mprq_pkg::REQ_REMOVE, 0, 0);
    push_req(mprq_pkg::REQ_REMOVE, 0, 0);
    push_req(3'd5, 63, 63);
    push_req(3'd6, 21, 42);
    push_req(3'd7, 42, 21);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    push_req(mprq_pkg::REQ_POP, 0, 0);
    for (int i = 0; i < 3; i++) push_req(mprq_pkg::REQ_INSERT, 6'(60 + i), 31);
    push_req(mprq_pkg::REQ_REMOVE, 61, 0);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    // random part, generated just ahead of the driver so it follows the queue state
    while (generated < NUM_RANDOM) begin
      @(posedge clk_i);
      if (pending_reqs.size() < 1 && expected_summaries.size() == 0) begin
        request_t r;
        filling = ((generated / 80) % 2 == 0) || (generated % 160 < 20);
        r = random_request(filling);
        r.drain = (generated == NUM_RANDOM / 2);
        pending_reqs.push_back(r);
        generated++;
        if (generated >= NUM_RANDOM - CALM_TAIL) calm = 1;
      end
    end
    wait (pending_reqs.size() == 0 && expected_summaries.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_summaries.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: multilevel_priority_ready_queue.f
+incdir+rtl/core
rtl/core/mprq_pkg.sv
rtl/core/mprq_ctrl.sv
rtl/core/mprq_dp.sv
rtl/core/multilevel_priority_ready_queue.sv
test/multilevel_priority_ready_queue_tb.sv
